// ===== design/bdgw_pkg.sv =====
// ----------------------------------------------------------------------------
// bdgw_pkg
// Shared types and constants for the gradient-weighted Bayer demosaic.
// ----------------------------------------------------------------------------
`default_nettype none

package bdgw_pkg;

  localparam int unsigned RawBits        = 10;
  localparam int unsigned PosBits        = 12;
  localparam int unsigned SizeBits       = 13;
  localparam int unsigned LineRows       = 4;
  localparam int unsigned PosLimit       = 4096;
  localparam int unsigned MaxLineWidthDef = 4096;
  localparam int unsigned DivSteps       = 8;

  localparam logic [SizeBits-1:0] WidthReset  = 13'd640;
  localparam logic [SizeBits-1:0] HeightReset = 13'd480;
  localparam logic [SizeBits-1:0] SizeMin     = 13'd5;

  // configuration register indexes
  localparam logic CfgFrameWidth  = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;

  typedef struct packed {
    logic accept;    // take an input beat, read the line store
    logic shift;     // shift the window, write the line store
    logic calc;      // averages and gradients
    logic mul;       // weight products
    logic sum;       // numerator, denominator, divider load
    logic div_step;  // one quotient bit
    logic load_out;  // move the result into the output register
  } bdgw_cmd_t;

  typedef struct packed {
    logic interior;  // current pixel has a result
    logic out_free;  // output register can take a result
  } bdgw_stat_t;

endpackage

`default_nettype wire

// ===== design/bdgw_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdgw_ctrl
// Sequencer: walks one pixel through read, window shift, math and output.
// ----------------------------------------------------------------------------
`default_nettype none

module bdgw_ctrl
  import bdgw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire bdgw_stat_t stat_i,
  output bdgw_cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StShift = 7'b0000010,
    StCalc  = 7'b0000100,
    StMul   = 7'b0001000,
    StSum   = 7'b0010000,
    StDiv   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  localparam int unsigned CntBits = $clog2(DivSteps);

  state_e              state_q, state_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = StShift;
      end
      StShift: begin
        cmd_o.shift = 1'b1;
        state_d = stat_i.interior ? StCalc : StIdle;
      end
      StCalc: begin
        cmd_o.calc = 1'b1;
        state_d = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        cnt_d = '0;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntBits'(DivSteps - 1)) state_d = StOut;
      end
      StOut: begin
        cmd_o.load_out = stat_i.out_free;
        if (stat_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/bdgw_datapath.sv =====
// ----------------------------------------------------------------------------
// bdgw_datapath
// Position counters, line store, 5x5 window, interpolation and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bdgw_datapath
  import bdgw_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH = MaxLineWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bdgw_cmd_t            cmd_i,
  output bdgw_stat_t                stat_o,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_index_i,
  input  wire logic [SizeBits-1:0]  cfg_data_i,
  input  wire logic [RawBits-1:0]   raw_pixel_i,
  input  wire logic                 frame_start_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [7:0]                red_o,
  output logic [7:0]                green_o,
  output logic [7:0]                blue_o,
  output logic [PosBits-1:0]        pixel_column_o,
  output logic [PosBits-1:0]        pixel_row_o,
  output logic                      frame_last_o
);

  localparam int unsigned AddrBits = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int unsigned WMaxInt  = (MAX_LINE_WIDTH < PosLimit) ? MAX_LINE_WIDTH : PosLimit;
  localparam logic [SizeBits-1:0] WMax  = SizeBits'(WMaxInt);
  localparam logic [SizeBits-1:0] HMax  = SizeBits'(PosLimit);
  localparam int unsigned WordBits = LineRows * RawBits;

  // ---- configuration ----
  logic [SizeBits-1:0] width_q, height_q, w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFrameWidth:  width_q  <= cfg_data_i;
        CfgFrameHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (width_q < SizeMin) ? SizeMin : ((width_q > WMax) ? WMax : width_q);
    h_eff = (height_q < SizeMin) ? SizeMin : ((height_q > HMax) ? HMax : height_q);
  end

  // ---- position ----
  logic [PosBits-1:0]  col_q, row_q, c_q, r_q;
  logic [PosBits-1:0]  c0, r0, c1, col_d, row_d;
  logic [SizeBits-1:0] r1, r2, cn, rn;
  logic                last_q;

  always_comb begin
    c0 = frame_start_i ? '0 : col_q;
    r0 = frame_start_i ? '0 : row_q;
    if ({1'b0, c0} >= w_eff) begin
      c1 = '0;
      r1 = {1'b0, r0} + 1'b1;
    end else begin
      c1 = c0;
      r1 = {1'b0, r0};
    end
    r2 = (r1 >= h_eff) ? '0 : r1;
    cn = {1'b0, c1} + 1'b1;
    rn = r2 + 1'b1;
    if (cn >= w_eff) begin
      col_d = '0;
      row_d = (rn >= h_eff) ? '0 : rn[PosBits-1:0];
    end else begin
      col_d = cn[PosBits-1:0];
      row_d = r2[PosBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  logic [RawBits-1:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q  <= raw_pixel_i;
      c_q    <= c1;
      r_q    <= r2[PosBits-1:0];
      last_q <= ({1'b0, c1} == w_eff - 1'b1) && (r2 == h_eff - 1'b1);
    end
  end

  assign stat_o.interior = (c_q >= PosBits'(4)) && (r_q >= PosBits'(4));

  // ---- line store: one word per column, four row slots ----
  logic [WordBits-1:0]          mem [MAX_LINE_WIDTH];
  logic [WordBits-1:0]          rd_q, wr_word;
  logic [PosBits+AddrBits-1:0]  rd_ext, wr_ext;
  logic [1:0]                   slot_w;

  assign rd_ext = {{AddrBits{1'b0}}, c1};
  assign wr_ext = {{AddrBits{1'b0}}, c_q};
  assign slot_w = r_q[1:0];

  always_comb begin
    wr_word = rd_q;
    wr_word[slot_w*RawBits +: RawBits] = pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) rd_q <= mem[rd_ext[AddrBits-1:0]];
    if (cmd_i.shift) mem[wr_ext[AddrBits-1:0]] <= wr_word;
  end

  // ---- window ----
  logic [RawBits-1:0] win_q [5][5];
  logic [1:0]         slot_r [LineRows];

  always_comb begin
    for (int i = 0; i < LineRows; i++) slot_r[i] = r_q[1:0] + 2'(i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int i = 0; i < 5; i++)
        for (int k = 0; k < 4; k++)
          win_q[i][k] <= win_q[i][k+1];
      for (int i = 0; i < LineRows; i++)
        win_q[i][4] <= rd_q[slot_r[i]*RawBits +: RawBits];
      win_q[4][4] <= pix_q;
    end
  end

  // ---- interpolation ----
  function automatic logic [11:0] abs13(input logic signed [12:0] v);
    logic signed [12:0] m;
    m = (v < 0) ? -v : v;
    return m[11:0];
  endfunction

  logic [10:0] hsum, vsum;
  logic [11:0] dsum, dh, dv;
  logic [9:0]  hav, vav;

  always_comb begin
    hsum = {1'b0, win_q[2][1]} + {1'b0, win_q[2][3]};
    vsum = {1'b0, win_q[1][2]} + {1'b0, win_q[3][2]};
    hav  = hsum[10:1];
    vav  = vsum[10:1];
    dsum = {2'b0, win_q[1][1]} + {2'b0, win_q[1][3]} +
           {2'b0, win_q[3][1]} + {2'b0, win_q[3][3]};
    dh = abs13(13'(signed'({3'b0, win_q[2][1]})) - 13'(signed'({3'b0, win_q[2][3]})))
       + abs13(13'(signed'({2'b0, win_q[2][2], 1'b0}))
               - 13'(signed'({3'b0, win_q[2][0]})) - 13'(signed'({3'b0, win_q[2][4]})));
    dv = abs13(13'(signed'({3'b0, win_q[1][2]})) - 13'(signed'({3'b0, win_q[3][2]})))
       + abs13(13'(signed'({2'b0, win_q[2][2], 1'b0}))
               - 13'(signed'({3'b0, win_q[0][2]})) - 13'(signed'({3'b0, win_q[4][2]})));
  end

  logic [9:0]  hav_q, vav_q;
  logic [11:0] dh_q, dv_q;
  logic [7:0]  red_q, blue_q, gnat_q;
  logic        rb_site_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      hav_q     <= hav;
      vav_q     <= vav;
      dh_q      <= dh;
      dv_q      <= dv;
      gnat_q    <= win_q[2][2][9:2];
      rb_site_q <= ~(c_q[0] ^ r_q[0]);
      if ((c_q[0] ^ r_q[0]) == 1'b1) begin
        // green site
        red_q  <= r_q[0] ? vav[9:2] : hav[9:2];
        blue_q <= r_q[0] ? hav[9:2] : vav[9:2];
      end else begin
        red_q  <= r_q[0] ? dsum[11:4] : win_q[2][2][9:2];
        blue_q <= r_q[0] ? win_q[2][2][9:2] : dsum[11:4];
      end
    end
  end

  // ---- weights and divide ----
  logic [21:0] p1_q, p2_q, dsh_q;
  logic [14:0] den_q;
  logic [22:0] rem_q;
  logic [7:0]  quo_q;
  logic [12:0] wsum;
  logic        ge;

  assign wsum = 13'd2 + {1'b0, dh_q} + {1'b0, dv_q};
  assign ge   = (rem_q >= {1'b0, dsh_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p1_q  <= (12'd1 + dv_q) * hav_q;
      p2_q  <= (12'd1 + dh_q) * vav_q;
      den_q <= {wsum[12:0], 2'b00};
    end
    if (cmd_i.sum) begin
      rem_q <= {1'b0, p1_q} + {1'b0, p2_q};
      dsh_q <= {den_q, 7'b0};
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (ge) rem_q <= rem_q - {1'b0, dsh_q};
      quo_q <= {quo_q[6:0], ge};
      dsh_q <= {1'b0, dsh_q[21:1]};
    end
  end

  // ---- output register ----
  assign stat_o.out_free = ~out_valid_o | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      red_o          <= red_q;
      blue_o         <= blue_q;
      green_o        <= rb_site_q ? quo_q : gnat_q;
      pixel_column_o <= c_q - PosBits'(2);
      pixel_row_o    <= r_q - PosBits'(2);
      frame_last_o   <= last_q;
    end
  end

endmodule

`default_nettype wire

// ===== design/bayer_demosaic_gradient_weighted_top.sv =====
// ----------------------------------------------------------------------------
// bayer_demosaic_gradient_weighted_top
// RGGB Bayer to 8-bit RGB demosaic with gradient-weighted green.
// ----------------------------------------------------------------------------
// Feed 10-bit RGGB samples in raster order, one per input beat; raise
// frame_start_i on pixel (0,0). Each pixel at least two in from every edge
// yields one RGB beat tagged with its column, row and a last-of-frame flag;
// border pixels yield nothing. The block works on one pixel at a time: a
// border pixel goes through accept and line store read-modify-write with
// window shift; an interior pixel goes on to interpolation, weight products,
// sum, a bit-serial restoring divide for green at red and blue sites and
// output load. A finished result waits in the output register, so the next
// pixel is taken while it is stalled.
// Write frame_width/frame_height only while idle; the line store is not
// cleared, so the first rows of a frame may see samples of older frames.
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_demosaic_gradient_weighted_top
  import bdgw_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH = MaxLineWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [SizeBits-1:0] cfg_data_i,
  // pixel input
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [RawBits-1:0]  raw_pixel_i,
  input  wire logic                frame_start_i,
  // RGB output
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [7:0]               red_o,
  output logic [7:0]               green_o,
  output logic [7:0]               blue_o,
  output logic [PosBits-1:0]       pixel_column_o,
  output logic [PosBits-1:0]       pixel_row_o,
  output logic                     frame_last_o
);

  bdgw_cmd_t  cmd;
  bdgw_stat_t stat;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  bdgw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bdgw_datapath #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .raw_pixel_i    (raw_pixel_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .frame_last_o   (frame_last_o)
  );

endmodule

`default_nettype wire

// ===== test/bayer_demosaic_gradient_weighted_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_demosaic_gradient_weighted_checker
// Watches the config, pixel and RGB channels of the demosaic, predicts each
// RGB beat from the accepted pixel beats and compares field by field.
// ----------------------------------------------------------------------------

module bayer_demosaic_gradient_weighted_checker
  import bdgw_pkg::*;
#(
  parameter int unsigned MAX_LINE_WIDTH = MaxLineWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_index_i,
  input  logic [SizeBits-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [RawBits-1:0]  raw_pixel_i,
  input  logic                frame_start_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic [PosBits-1:0]  pixel_column_i,
  input  logic [PosBits-1:0]  pixel_row_i,
  input  logic                frame_last_i,
  output int                  fail_count_o,
  output int                  rgb_pending_o,
  output int                  rgb_seen_o
);

  localparam int unsigned WidthMax = (MAX_LINE_WIDTH < PosLimit) ? MAX_LINE_WIDTH : PosLimit;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [PosBits-1:0] col;
    logic [PosBits-1:0] row;
    logic               last;
  } rgb_beat_t;

  rgb_beat_t            rgb_expected[$];
  logic [SizeBits-1:0]  width_reg;
  logic [SizeBits-1:0]  height_reg;
  logic [RawBits-1:0]   line_mem[LineRows*MAX_LINE_WIDTH];
  logic [RawBits-1:0]   win[5][5];
  int unsigned          col_cnt;
  int unsigned          row_cnt;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < SizeMin) return SizeMin;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int tap(int dy, int dx);
    return int'(win[2+dy][2+dx]);
  endfunction

  task automatic predict_pixel(logic [RawBits-1:0] pix, logic fs);
    int unsigned w, h, c, r, cx, cy, num, den;
    int          cen, hav, vav, dh, dv, diag, rd, gr, bl;
    rgb_beat_t   beat;
    w = clamp_size(width_reg, WidthMax);
    h = clamp_size(height_reg, PosLimit);
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    c = col_cnt;
    r = row_cnt;
    for (int i = 0; i < 5; i++)
      for (int k = 0; k < 4; k++) win[i][k] = win[i][k+1];
    for (int i = 0; i < LineRows; i++)
      win[i][4] = line_mem[((r + i) & 3) * MAX_LINE_WIDTH + c];
    win[4][4] = pix;
    line_mem[(r & 3) * MAX_LINE_WIDTH + c] = pix;
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = r + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    if (c < 4 || r < 4) return;
    cx  = c - 2;
    cy  = r - 2;
    cen = tap(0, 0);
    hav = (tap(0, -1) + tap(0, 1)) >>> 1;
    vav = (tap(-1, 0) + tap(1, 0)) >>> 1;
    if (((cx ^ cy) & 1) != 0) begin
      // green site: both missing colors from the straight neighbors
      gr = cen >>> 2;
      if ((cy & 1) == 0) begin
        rd = hav >>> 2;
        bl = vav >>> 2;
      end else begin
        bl = hav >>> 2;
        rd = vav >>> 2;
      end
    end else begin
      dh   = iabs(tap(0, -1) - tap(0, 1)) + iabs(2*cen - tap(0, -2) - tap(0, 2));
      dv   = iabs(tap(-1, 0) - tap(1, 0)) + iabs(2*cen - tap(-2, 0) - tap(2, 0));
      num  = (1 + dv) * hav + (1 + dh) * vav;
      den  = 4 * (2 + dh + dv);
      diag = ((tap(-1, -1) + tap(-1, 1) + tap(1, -1) + tap(1, 1)) >>> 2) >>> 2;
      gr   = num / den;
      if ((cy & 1) == 0) begin
        rd = cen >>> 2;
        bl = diag;
      end else begin
        bl = cen >>> 2;
        rd = diag;
      end
    end
    beat.red   = rd[7:0];
    beat.green = gr[7:0];
    beat.blue  = bl[7:0];
    beat.col   = cx[PosBits-1:0];
    beat.row   = cy[PosBits-1:0];
    beat.last  = (c == w - 1 && r == h - 1);
    rgb_expected.push_back(beat);
  endtask

  initial begin
    width_reg    = WidthReset;
    height_reg   = HeightReset;
    col_cnt      = 0;
    row_cnt      = 0;
    fail_count_o = 0;
    rgb_seen_o   = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i, k]) win[i][k] = '0;
  end

  assign rgb_pending_o = rgb_expected.size();

  always @(posedge clk_i) begin
    rgb_beat_t got, want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgFrameWidth) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) predict_pixel(raw_pixel_i, frame_start_i);
      if (out_valid_i && !out_stall_i) begin
        got = '{red_i, green_i, blue_i, pixel_column_i, pixel_row_i, frame_last_i};
        rgb_seen_o++;
        if (rgb_expected.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("ERROR: unexpected RGB beat col %0d row %0d", got.col, got.row);
        end else begin
          want = rgb_expected.pop_front();
          if (got != want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("ERROR: RGB beat exp r%0d g%0d b%0d c%0d r%0d l%0d, got r%0d g%0d b%0d c%0d r%0d l%0d",
                       want.red, want.green, want.blue, want.col, want.row, want.last,
                       got.red, got.green, got.blue, got.col, got.row, got.last);
          end
        end
      end
    end
  end

endmodule

// ===== test/bayer_demosaic_gradient_weighted_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_demosaic_gradient_weighted_top_test
// Drives frames of Bayer samples through the demosaic at several frame sizes
// with random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------

module bayer_demosaic_gradient_weighted_top_test;
  import bdgw_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int HoldOffCycles = 400;
  localparam int RandomItems   = 1350;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i = CfgFrameWidth;
  logic [SizeBits-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [RawBits-1:0]  raw_pixel_i = '0;
  logic                frame_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          red_o, green_o, blue_o;
  logic [PosBits-1:0]  pixel_column_o, pixel_row_o;
  logic                frame_last_o;

  int fail_count, rgb_pending, rgb_seen;
  int pixels_sent = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;   // no gaps or stalls on either side
  bit hold_go     = 1'b0;   // request one long output hold-off

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  bayer_demosaic_gradient_weighted_top uut (.*);

  bayer_demosaic_gradient_weighted_checker chk (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .raw_pixel_i, .frame_start_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .red_i(red_o), .green_i(green_o), .blue_i(blue_o),
    .pixel_column_i(pixel_column_o), .pixel_row_i(pixel_row_o),
    .frame_last_i(frame_last_o),
    .fail_count_o(fail_count), .rgb_pending_o(rgb_pending), .rgb_seen_o(rgb_seen)
  );

  // Receiver: random stalls, plus one long hold-off counted here so the
  // block fills up and pushes back on the pixel side.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HoldOffCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet_phase && ($urandom_range(99) < 11);
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles", WatchdogLimit);
      $display("bayer_demosaic_gradient_weighted_top verification failed");
      $finish;
    end
  end

  // Drop the pixel valid, wait until every predicted RGB beat has come out,
  // then let the block settle before touching the registers.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (rgb_pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Offer one register beat and hold it until taken; the caller drops valid.
  task automatic write_reg(logic idx, logic [SizeBits-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic configure(logic [SizeBits-1:0] w, logic [SizeBits-1:0] h);
    drain_block();
    write_reg(CfgFrameWidth, w);
    write_reg(CfgFrameHeight, h);
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one pixel beat; hold it until taken. Valid stays high into the
  // next beat unless a random gap drops it.
  task automatic send_pixel(logic [RawBits-1:0] pix, logic fs);
    if (!quiet_phase && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    raw_pixel_i   <= pix;
    frame_start_i <= fs;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    pixels_sent++;
  endtask

  // Bias toward the extremes so saturated gradients show up often.
  function automatic logic [RawBits-1:0] pick_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return RawBits'($urandom);
    endcase
  endfunction

  task automatic send_frame(int w, int h, bit with_start, int noise_pct);
    for (int i = 0; i < w * h; i++)
      send_pixel(pick_pixel(), (with_start && i == 0) || ($urandom_range(99) < noise_pct));
  endtask

  initial begin
    int w, h, phase;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Widest random line first with the smallest height (zero clamps up);
    // this fills every line store entry that later frames can reach.
    configure(SizeBits'(16), SizeBits'(0));
    send_frame(16, 5, 1'b1, 0);

    // Directed checkerboard of full-scale and zero samples at the minimum
    // size (a width below the minimum clamps up).
    configure(SizeBits'(3), SizeBits'(5));
    for (int i = 0; i < 25; i++)
      send_pixel((((i % 5) ^ (i / 5)) & 1) ? '1 : '0, i == 0);

    // Thin frame, ending in the last-of-frame beat.
    configure(SizeBits'(5), SizeBits'(9));
    send_frame(5, 9, 1'b1, 0);

    // Shrink the width mid-row without a frame start: the position lands
    // past the new width and starts a new row.
    configure(SizeBits'(12), SizeBits'(7));
    send_frame(12, 3, 1'b1, 0);
    for (int i = 0; i < 7; i++) send_pixel(pick_pixel(), 1'b0);
    configure(SizeBits'(6), SizeBits'(7));
    send_frame(6, 9, 1'b0, 0);

    // Random frames: mostly whole frames with a frame start, some running
    // on through the wrap, a little stray frame-start noise.
    phase = 0;
    while (pixels_sent < RandomItems - 100) begin
      w = ($urandom_range(3) == 0) ? 5 : $urandom_range(16, 5);
      h = $urandom_range(9, 5);
      configure(SizeBits'(w), SizeBits'(h));
      quiet_phase = (phase == 4);
      if (phase == 2) hold_go = 1'b1;
      repeat ($urandom_range(2, 1))
        send_frame(w, h, $urandom_range(3) != 0, ($urandom_range(4) == 0) ? 3 : 0);
      quiet_phase = 1'b0;
      phase++;
    end

    drain_block();
    repeat (40) @(posedge clk_i);
    $display("covered %0d pixel beats, %0d RGB beats, %0d random frame phases",
             pixels_sent, rgb_seen, phase);
    $display("sizes from 5x5 to 16-wide and 9-tall, clamped writes, mid-row shrink");
    if (fail_count == 0 && rgb_pending == 0) begin
      $display("bayer_demosaic_gradient_weighted_top verification clean");
    end else begin
      $display("%0d mismatches, %0d RGB beats missing", fail_count, rgb_pending);
      $display("bayer_demosaic_gradient_weighted_top verification failed");
    end
    $finish;
  end

endmodule

// ===== bayer_demosaic_gradient_weighted_top.f =====
design/bdgw_pkg.sv
design/bdgw_ctrl.sv
design/bdgw_datapath.sv
design/bayer_demosaic_gradient_weighted_top.sv
test/bayer_demosaic_gradient_weighted_checker.sv
test/bayer_demosaic_gradient_weighted_top_test.sv
